>>> rtl/rspa_pkg.sv
// ---------------------------------------------------------------------------
// rspa_pkg
// Shared codes, widths and the command type passed from the front end to
// the execution back end of the slot pool allocator.
// ---------------------------------------------------------------------------
package rspa_pkg;

  // field widths
  localparam int OPCODE_W    = 2;
  localparam int KIND_W      = 2;
  localparam int LEN_W       = 8;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 8;
  localparam int USED_OUT_W  = 5;
  localparam int STAT_W      = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RETAIN  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

  // message kinds
  localparam logic [KIND_W-1:0] KIND_PURE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMON  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DYNAMIC = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_COMMON_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DYNAMIC_LIMIT = 2'd1;

  // configuration reset values
  localparam logic [LEN_W-1:0] COMMON_LIMIT_RST  = 8'd32;
  localparam logic [LEN_W-1:0] DYNAMIC_LIMIT_RST = 8'd255;

  // reference count limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 8'd1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // classified operation
  typedef enum logic [2:0] {
    CMD_REJECT,   // allocate refused on length or kind
    CMD_ALLOC,    // allocate that passed the length check
    CMD_RETAIN,
    CMD_RELEASE,
    CMD_PEEK,     // unknown opcode on an addressable slot
    CMD_RANGE     // retain, release or peek on a slot outside the pool
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

>>> rtl/rspa_front.sv
// ---------------------------------------------------------------------------
// rspa_front
// Holds the length limit registers, accepts items and classifies each one
// into a command for the back end.
// ---------------------------------------------------------------------------
module rspa_front
  import rspa_pkg::*;
#(
  parameter int POOL_SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [LEN_W-1:0]       in_payload_length,
  input  logic [SLOT_W-1:0]      in_slot,
  output logic                   push_valid,
  input  logic                   push_ready,
  output cmd_t                   push_cmd
);

  logic [LEN_W-1:0] common_limit_r;
  logic [LEN_W-1:0] dynamic_limit_r;
  logic             fits;
  logic             in_range;

  // length limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      common_limit_r  <= COMMON_LIMIT_RST;
      dynamic_limit_r <= DYNAMIC_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMMON_LIMIT:  common_limit_r  <= cfg_wdata;
        CFG_DYNAMIC_LIMIT: dynamic_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // length check for allocate
  always_comb begin
    case (in_kind)
      KIND_PURE:    fits = (in_payload_length == '0);
      KIND_COMMON:  fits = (in_payload_length <= common_limit_r);
      KIND_DYNAMIC: fits = (in_payload_length <= dynamic_limit_r);
      default:      fits = 1'b0;
    endcase
  end

  assign in_range = (32'(in_slot) < 32'(POOL_SLOTS));

  // classify the item
  always_comb begin
    push_cmd.slot = in_slot;
    if (in_opcode == OP_ALLOC) begin
      push_cmd.kind = fits ? CMD_ALLOC : CMD_REJECT;
    end else if (!in_range) begin
      push_cmd.kind = CMD_RANGE;
    end else begin
      case (in_opcode)
        OP_RETAIN:  push_cmd.kind = CMD_RETAIN;
        OP_RELEASE: push_cmd.kind = CMD_RELEASE;
        default:    push_cmd.kind = CMD_PEEK;
      endcase
    end
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

>>> rtl/rspa_queue.sv
// ---------------------------------------------------------------------------
// rspa_queue
// Small command queue between the front end and the back end.
// ---------------------------------------------------------------------------
module rspa_queue
  import rspa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] wptr_nxt;
  logic [PTR_W-1:0] rptr_r;
  logic [PTR_W-1:0] rptr_nxt;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = entry_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill updates
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/rspa_back.sv
// ---------------------------------------------------------------------------
// rspa_back
// Executes commands against the slot map, reference counts and statistics
// and holds the result item in an output register.
// ---------------------------------------------------------------------------
module rspa_back
  import rspa_pkg::*;
#(
  parameter int POOL_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  cmd_t                  pop_cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ok,
  output logic [SLOT_W-1:0]     out_slot_index,
  output logic [COUNT_W-1:0]    out_count_after,
  output logic [USED_OUT_W-1:0] out_used_now,
  output logic [USED_OUT_W-1:0] out_used_peak,
  output logic [STAT_W-1:0]     out_alloc_total,
  output logic [STAT_W-1:0]     out_alloc_failed,
  output logic [STAT_W-1:0]     out_release_total
);

  localparam int IDX_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int USED_W = $clog2(POOL_SLOTS + 1);

  logic [COUNT_W-1:0]    count_r [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] map_r;
  logic [POOL_SLOTS-1:0] map_nxt;
  logic [USED_W-1:0]     used_r;
  logic [USED_W-1:0]     used_nxt;
  logic [USED_W-1:0]     peak_r;
  logic [USED_W-1:0]     peak_nxt;
  logic [STAT_W-1:0]     alloc_r;
  logic [STAT_W-1:0]     alloc_nxt;
  logic [STAT_W-1:0]     fail_r;
  logic [STAT_W-1:0]     fail_nxt;
  logic [STAT_W-1:0]     free_r;
  logic [STAT_W-1:0]     free_nxt;

  logic                  out_valid_r;
  logic                  ok_r;
  logic                  ok_nxt;
  logic [SLOT_W-1:0]     slot_idx_r;
  logic [SLOT_W-1:0]     slot_idx_nxt;
  logic [COUNT_W-1:0]    cnt_after_r;
  logic [COUNT_W-1:0]    cnt_after_nxt;

  logic                  exec;
  logic [IDX_W-1:0]      addr;
  logic [COUNT_W-1:0]    cur_cnt;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_found;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_widx;
  logic [COUNT_W-1:0]    cnt_wdata;

  // take a command when the output register is free or being drained
  assign pop_ready = !out_valid_r || out_ready;
  assign exec      = pop_valid && pop_ready;

  assign addr    = IDX_W'((IDX_W + SLOT_W)'(pop_cmd.slot));
  assign cur_cnt = count_r[addr];

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!map_r[i]) begin
        free_idx   = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  // command execution
  always_comb begin
    map_nxt       = map_r;
    used_nxt      = used_r;
    peak_nxt      = peak_r;
    alloc_nxt     = alloc_r;
    fail_nxt      = fail_r;
    free_nxt      = free_r;
    cnt_we        = 1'b0;
    cnt_widx      = addr;
    cnt_wdata     = cur_cnt;
    ok_nxt        = 1'b0;
    slot_idx_nxt  = pop_cmd.slot;
    cnt_after_nxt = '0;
    case (pop_cmd.kind)
      CMD_REJECT: begin
        slot_idx_nxt = '0;
      end
      CMD_ALLOC: begin
        slot_idx_nxt = '0;
        if (free_found) begin
          map_nxt[free_idx] = 1'b1;
          cnt_we            = 1'b1;
          cnt_widx          = free_idx;
          cnt_wdata         = COUNT_ONE;
          used_nxt          = used_r + 1'b1;
          alloc_nxt         = alloc_r + 1'b1;
          if (used_nxt > peak_r) begin
            peak_nxt = used_nxt;
          end
          ok_nxt        = 1'b1;
          slot_idx_nxt  = SLOT_W'((IDX_W + SLOT_W)'(free_idx));
          cnt_after_nxt = COUNT_ONE;
        end else begin
          fail_nxt = fail_r + 1'b1;
        end
      end
      CMD_RETAIN: begin
        if (cur_cnt != '0 && cur_cnt != COUNT_MAX) begin
          cnt_we        = 1'b1;
          cnt_wdata     = cur_cnt + 1'b1;
          ok_nxt        = 1'b1;
          cnt_after_nxt = cur_cnt + 1'b1;
        end else begin
          cnt_after_nxt = cur_cnt;
        end
      end
      CMD_RELEASE: begin
        if (cur_cnt != '0) begin
          cnt_we        = 1'b1;
          cnt_wdata     = cur_cnt - 1'b1;
          ok_nxt        = 1'b1;
          cnt_after_nxt = cur_cnt - 1'b1;
          // last reference gone: free the slot
          if (cur_cnt == COUNT_ONE && map_r[addr]) begin
            map_nxt[addr] = 1'b0;
            if (used_r != '0) begin
              used_nxt = used_r - 1'b1;
            end
            free_nxt = free_r + 1'b1;
          end
        end
      end
      CMD_PEEK: begin
        cnt_after_nxt = cur_cnt;
      end
      default: begin
        cnt_after_nxt = '0;
      end
    endcase
  end

  // pool state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r   <= '0;
      used_r  <= '0;
      peak_r  <= '0;
      alloc_r <= '0;
      fail_r  <= '0;
      free_r  <= '0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
        count_r[i] <= '0;
      end
    end else if (exec) begin
      map_r   <= map_nxt;
      used_r  <= used_nxt;
      peak_r  <= peak_nxt;
      alloc_r <= alloc_nxt;
      fail_r  <= fail_nxt;
      free_r  <= free_nxt;
      if (cnt_we) begin
        count_r[cnt_widx] <= cnt_wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      ok_r        <= ok_nxt;
      slot_idx_r  <= slot_idx_nxt;
      cnt_after_r <= cnt_after_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = ok_r;
  assign out_slot_index    = slot_idx_r;
  assign out_count_after   = cnt_after_r;
  assign out_used_now      = USED_OUT_W'(used_r);
  assign out_used_peak     = USED_OUT_W'(peak_r);
  assign out_alloc_total   = alloc_r;
  assign out_alloc_failed  = fail_r;
  assign out_release_total = free_r;

endmodule

>>> rtl/refcounted_slot_pool_allocator_core.sv
// ---------------------------------------------------------------------------
// refcounted_slot_pool_allocator_core
// Reference-counted pool of message slots: allocate, retain and release.
// ---------------------------------------------------------------------------
// Each item is one operation and yields exactly one result item carrying the
// slot, its count afterwards and the usage statistics. The front end checks
// the payload length against the kind's limit and queues a classified
// command; the back end finds the lowest free slot and updates one count in
// the same cycle, so one item is taken per clock in steady state unless the
// output is held. An accepted item passes through the command queue and then
// the output register before its result is valid. The limit registers must
// only be written while no item is in flight.
module refcounted_slot_pool_allocator_core
  import rspa_pkg::*;
#(
  parameter int POOL_SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [LEN_W-1:0]       in_payload_length,
  input  logic [SLOT_W-1:0]      in_slot,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_ok,
  output logic [SLOT_W-1:0]      out_slot_index,
  output logic [COUNT_W-1:0]     out_count_after,
  output logic [USED_OUT_W-1:0]  out_used_now,
  output logic [USED_OUT_W-1:0]  out_used_peak,
  output logic [STAT_W-1:0]      out_alloc_total,
  output logic [STAT_W-1:0]      out_alloc_failed,
  output logic [STAT_W-1:0]      out_release_total
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // decode and length check
  rspa_front #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_kind          (in_kind),
    .in_payload_length(in_payload_length),
    .in_slot          (in_slot),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_cmd         (push_cmd)
  );

  // command queue
  rspa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  // pool state and results
  rspa_back #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_cmd          (pop_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_slot_index   (out_slot_index),
    .out_count_after  (out_count_after),
    .out_used_now     (out_used_now),
    .out_used_peak    (out_used_peak),
    .out_alloc_total  (out_alloc_total),
    .out_alloc_failed (out_alloc_failed),
    .out_release_total(out_release_total)
  );

endmodule
